>>> rtl/core/dles_pkg.sv
// ----------------------------------------------------------------------------
// dles_pkg
// Shared types and codes for the dual-list event scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package dles_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_ADJUST = 3'd2;
    localparam logic [2:0] OP_GETNXT = 3'd3;
    localparam logic [2:0] OP_HANDLE = 3'd4;
    localparam logic [2:0] OP_SUB    = 3'd5;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam int IN_BITS  = 56;
    localparam int OUT_BITS = 72;
    localparam int WIDE     = 65;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_SCAN2,
        FSM_FINISH
    } fsm_t;

endpackage

`default_nettype wire

>>> rtl/core/dles_cell.sv
// ----------------------------------------------------------------------------
// dles_cell
// One slot of a rotating event ring: valid bit, callback id and due time.
// ----------------------------------------------------------------------------
`default_nettype none

module dles_cell #(
    parameter int TW = 48
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 shift,
    input  wire logic                 in_valid,
    input  wire logic [2:0]           in_id,
    input  wire logic signed [TW-1:0] in_time,
    output logic                      valid,
    output logic [2:0]                id,
    output logic signed [TW-1:0]      time_val
);

    logic                 valid_reg;
    logic [2:0]           id_reg;
    logic signed [TW-1:0] time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            id_reg    <= '0;
            time_reg  <= '0;
        end
        else if (shift)
        begin
            valid_reg <= in_valid;
            id_reg    <= in_id;
            time_reg  <= in_time;
        end
    end

    assign valid    = valid_reg;
    assign id       = id_reg;
    assign time_val = time_reg;

endmodule

`default_nettype wire

>>> rtl/core/dles_ring.sv
// ----------------------------------------------------------------------------
// dles_ring
// A ring of slot cells. Cell 0 is the head; the tail cell loads the
// (possibly modified) head entry so that a full turn restores slot order.
// ----------------------------------------------------------------------------
`default_nettype none

module dles_ring #(
    parameter int SLOTS = 32,
    parameter int TW    = 48
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 shift,
    input  wire logic                 tail_valid,
    input  wire logic [2:0]           tail_id,
    input  wire logic signed [TW-1:0] tail_time,
    output logic                      head_valid,
    output logic [2:0]                head_id,
    output logic signed [TW-1:0]      head_time
);

    logic                 c_valid [SLOTS];
    logic [2:0]           c_id    [SLOTS];
    logic signed [TW-1:0] c_time  [SLOTS];

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        if (k == SLOTS - 1)
        begin : g_tail
            dles_cell #(.TW(TW)) u_cell (
                .clk(clk), .rst_n(rst_n), .shift(shift),
                .in_valid(tail_valid), .in_id(tail_id), .in_time(tail_time),
                .valid(c_valid[k]), .id(c_id[k]), .time_val(c_time[k])
            );
        end
        else
        begin : g_mid
            dles_cell #(.TW(TW)) u_cell (
                .clk(clk), .rst_n(rst_n), .shift(shift),
                .in_valid(c_valid[k+1]), .in_id(c_id[k+1]), .in_time(c_time[k+1]),
                .valid(c_valid[k]), .id(c_id[k]), .time_val(c_time[k])
            );
        end
    end

    assign head_valid = c_valid[0];
    assign head_id    = c_id[0];
    assign head_time  = c_time[0];

endmodule

`default_nettype wire

>>> rtl/core/dual_list_event_scheduler.sv
// ----------------------------------------------------------------------------
// dual_list_event_scheduler
// Two unordered event tables held as rotating rings of slot cells, with
// insert, remove, adjust, get-next, handle-next and subtract operations.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Beat carries
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | op, list_sel, callback_id, time_value
//  m_axis   | out       | status, next_time, next_slot, fired_id, event_count
//
// Each list is a ring of SLOTS cells that turns one slot per cycle while an
// operation runs; the controller inspects and rewrites the head slot as it
// passes to the tail. A beat takes one turn of the rings, and handle-next
// takes two turns: the first turn fetches the remembered slot's time and
// the second subtracts it. Undefined op codes go straight to the result
// without a turn. Reset clears every slot (valid, id and time), the
// remembered slots and the event count. A new beat is taken only when the
// controller is idle; a finished result waits in the output register while
// the next operation runs, and the controller stalls at its end only if that
// register is still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_list_event_scheduler
    import dles_pkg::*;
#(
    parameter int SLOTS     = 32,
    parameter int TIME_BITS = 48
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // [2:0] op, [3] list_sel, [6:4] callback_id, [54:7] time_value, [55] zero
    input  wire logic [IN_BITS-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [1:0] status, [49:2] next_time, [54:50] next_slot, [57:55] fired_id,
    // [64:58] event_count, [71:65] zero
    output logic [OUT_BITS-1:0]      m_axis_tdata
);

    localparam int TW = TIME_BITS;
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(2 * SLOTS + 1);
    localparam logic [IW:0] LAST_STEP = (IW + 1)'(SLOTS - 1);
    localparam logic signed [WIDE-1:0] TMAX_W = (65'sd1 <<< (TW - 1)) - 65'sd1;
    localparam logic signed [WIDE-1:0] TMIN_W = -TMAX_W - 65'sd1;
    localparam logic signed [WIDE-1:0] OMAX_W = 65'sh7FFFFFFFFFFF;
    localparam logic signed [WIDE-1:0] OMIN_W = -OMAX_W - 65'sd1;

    // Saturating a - b in the slot time format.
    function automatic logic signed [TW-1:0] sat_sub(
        input logic signed [TW-1:0] a,
        input logic signed [TW-1:0] b
    );
        logic signed [TW:0] d;
        d = {a[TW-1], a} - {b[TW-1], b};
        if (d[TW] != d[TW-1])
            sat_sub = d[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
        else
            sat_sub = d[TW-1:0];
    endfunction

    // Slot time to the 48-bit result field, saturating.
    function automatic logic [47:0] to_out(input logic signed [TW-1:0] t);
        logic signed [WIDE-1:0] w;
        w = WIDE'(t);
        if (w > OMAX_W)
            w = OMAX_W;
        else if (w < OMIN_W)
            w = OMIN_W;
        to_out = w[47:0];
    endfunction

    // Input time field clamped to the slot time range.
    logic signed [WIDE-1:0] in_wide;
    logic signed [WIDE-1:0] in_clamp;

    always_comb
    begin
        in_wide = WIDE'($signed(s_axis_tdata[54:7]));
        if (in_wide > TMAX_W)
            in_clamp = TMAX_W;
        else if (in_wide < TMIN_W)
            in_clamp = TMIN_W;
        else
            in_clamp = in_wide;
    end

    // Controller state.
    fsm_t                 fsm_reg, fsm_next;
    logic [2:0]           op_reg, op_next;
    logic                 sel_reg, sel_next;
    logic [2:0]           id_reg, id_next;
    logic signed [TW-1:0] tval_reg, tval_next;
    logic [IW:0]          step_reg, step_next;
    logic                 found_reg, found_next;
    logic signed [TW-1:0] best_reg, best_next;
    logic [IW-1:0]        bslot_reg, bslot_next;
    logic signed [TW-1:0] amount_reg, amount_next;
    logic                 hvalid_reg, hvalid_next;
    logic [2:0]           hid_reg, hid_next;
    logic [IW-1:0]        main_nxt_reg, main_nxt_next;
    logic [IW-1:0]        aux_nxt_reg, aux_nxt_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 ovalid_reg, ovalid_next;
    logic [OUT_BITS-1:0]  odata_reg, odata_next;

    // Ring heads and tails.
    logic                 shift;
    logic                 m_hv, a_hv, m_tv, a_tv;
    logic [2:0]           m_hid, a_hid, m_tid, a_tid;
    logic signed [TW-1:0] m_ht, a_ht, m_tt, a_tt;

    dles_ring #(.SLOTS(SLOTS), .TW(TW)) u_main (
        .clk(clk), .rst_n(rst_n), .shift(shift),
        .tail_valid(m_tv), .tail_id(m_tid), .tail_time(m_tt),
        .head_valid(m_hv), .head_id(m_hid), .head_time(m_ht)
    );

    dles_ring #(.SLOTS(SLOTS), .TW(TW)) u_aux (
        .clk(clk), .rst_n(rst_n), .shift(shift),
        .tail_valid(a_tv), .tail_id(a_tid), .tail_time(a_tt),
        .head_valid(a_hv), .head_id(a_hid), .head_time(a_ht)
    );

    logic                 h_v;
    logic [2:0]           h_id;
    logic signed [TW-1:0] h_t;
    logic [IW-1:0]        idx;
    logic [IW-1:0]        rem_slot;
    logic                 at_rem;
    logic                 out_free;
    logic [1:0]           r_status;
    logic [47:0]          r_time;
    logic [IW-1:0]        r_slot;
    logic [IW+4:0]        r_slot_ext;
    logic [2:0]           r_fired;
    logic [CW+6:0]        r_count_ext;

    assign h_v      = sel_reg ? a_hv : m_hv;
    assign h_id     = sel_reg ? a_hid : m_hid;
    assign h_t      = sel_reg ? a_ht : m_ht;
    assign idx      = step_reg[IW-1:0];
    assign rem_slot = sel_reg ? aux_nxt_reg : main_nxt_reg;
    assign at_rem   = (idx == rem_slot);
    assign out_free = !ovalid_reg || m_axis_tready;
    assign shift    = (fsm_reg == FSM_SCAN) || (fsm_reg == FSM_SCAN2);

    always_comb
    begin
        fsm_next      = fsm_reg;
        op_next       = op_reg;
        sel_next      = sel_reg;
        id_next       = id_reg;
        tval_next     = tval_reg;
        step_next     = step_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        bslot_next    = bslot_reg;
        amount_next   = amount_reg;
        hvalid_next   = hvalid_reg;
        hid_next      = hid_reg;
        main_nxt_next = main_nxt_reg;
        aux_nxt_next  = aux_nxt_reg;
        count_next    = count_reg;
        ovalid_next   = ovalid_reg;
        odata_next    = odata_reg;
        s_axis_tready = 1'b0;
        m_tv = m_hv; m_tid = m_hid; m_tt = m_ht;
        a_tv = a_hv; a_tid = a_hid; a_tt = a_ht;
        r_status = ST_DONE;
        r_time   = '0;
        r_slot   = '0;
        r_fired  = '0;
        r_slot_ext  = '0;
        r_count_ext = '0;

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        unique case (fsm_reg)
            FSM_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tdata[2:0];
                    sel_next   = s_axis_tdata[3];
                    id_next    = s_axis_tdata[6:4];
                    tval_next  = in_clamp[TW-1:0];
                    step_next  = '0;
                    found_next = 1'b0;
                    bslot_next = '0;
                    hvalid_next = 1'b0;
                    hid_next   = '0;
                    fsm_next   = (s_axis_tdata[2:0] <= OP_SUB) ? FSM_SCAN : FSM_FINISH;
                end
            end

            FSM_SCAN:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (!h_v && !found_reg)
                        begin
                            found_next = 1'b1;
                            if (sel_reg)
                            begin
                                a_tv = 1'b1; a_tid = id_reg; a_tt = tval_reg;
                            end
                            else
                            begin
                                m_tv = 1'b1; m_tid = id_reg; m_tt = tval_reg;
                            end
                        end
                    end
                    OP_REMOVE, OP_ADJUST:
                    begin
                        if (!found_reg)
                        begin
                            if (m_hv && m_hid == id_reg)
                            begin
                                found_next = 1'b1;
                                if (op_reg == OP_REMOVE)
                                    m_tv = 1'b0;
                                else
                                    m_tt = tval_reg;
                            end
                            else if (a_hv && a_hid == id_reg)
                            begin
                                found_next = 1'b1;
                                if (op_reg == OP_REMOVE)
                                    a_tv = 1'b0;
                                else
                                    a_tt = tval_reg;
                            end
                        end
                    end
                    OP_GETNXT:
                    begin
                        if (h_v && (!found_reg || h_t < best_reg))
                        begin
                            found_next = 1'b1;
                            best_next  = h_t;
                            bslot_next = idx;
                        end
                    end
                    OP_HANDLE:
                    begin
                        if (at_rem)
                        begin
                            amount_next = h_t;
                            hvalid_next = h_v;
                            hid_next    = h_id;
                        end
                    end
                    OP_SUB:
                    begin
                        if (sel_reg)
                            a_tt = sat_sub(a_ht, tval_reg);
                        else
                            m_tt = sat_sub(m_ht, tval_reg);
                    end
                    default:
                    begin
                    end
                endcase
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    step_next = '0;
                    fsm_next  = (op_reg == OP_HANDLE) ? FSM_SCAN2 : FSM_FINISH;
                end
            end

            FSM_SCAN2:
            begin
                // Second turn of handle-next: subtract the fetched time and clear the remembered slot.
                if (sel_reg)
                begin
                    a_tt = sat_sub(a_ht, amount_reg);
                    if (at_rem)
                        a_tv = 1'b0;
                end
                else
                begin
                    m_tt = sat_sub(m_ht, amount_reg);
                    if (at_rem)
                        m_tv = 1'b0;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    fsm_next = FSM_FINISH;
            end

            FSM_FINISH:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (found_reg)
                            count_next = count_reg + 1'b1;
                        else
                            r_status = ST_FULL;
                    end
                    OP_REMOVE:
                    begin
                        if (found_reg)
                            count_next = count_reg - 1'b1;
                        else
                            r_status = ST_NOMATCH;
                    end
                    OP_ADJUST:
                    begin
                        if (!found_reg)
                            r_status = ST_NOMATCH;
                    end
                    OP_GETNXT:
                    begin
                        r_slot = bslot_reg;
                        if (found_reg)
                            r_time = to_out(best_reg);
                        else
                        begin
                            r_status = ST_EMPTY;
                            r_time   = to_out({1'b0, {(TW-1){1'b1}}});
                        end
                        if (sel_reg)
                            aux_nxt_next = bslot_reg;
                        else
                            main_nxt_next = bslot_reg;
                    end
                    OP_HANDLE:
                    begin
                        r_slot = rem_slot;
                        if (hvalid_reg)
                        begin
                            r_fired    = hid_reg;
                            count_next = count_reg - 1'b1;
                        end
                        else
                            r_status = ST_EMPTY;
                    end
                    default:
                    begin
                    end
                endcase
                r_slot_ext  = {5'd0, r_slot};
                r_count_ext = {7'd0, count_next};
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {7'd0, r_count_ext[6:0], r_fired, r_slot_ext[4:0],
                                   r_time, r_status};
                    fsm_next    = FSM_IDLE;
                end
                else
                    count_next = count_reg;
                if (!out_free)
                begin
                    main_nxt_next = main_nxt_reg;
                    aux_nxt_next  = aux_nxt_reg;
                end
            end

            default:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg      <= FSM_IDLE;
            main_nxt_reg <= '0;
            aux_nxt_reg  <= '0;
            count_reg    <= '0;
            ovalid_reg   <= 1'b0;
            step_reg     <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            fsm_reg      <= fsm_next;
            main_nxt_reg <= main_nxt_next;
            aux_nxt_reg  <= aux_nxt_next;
            count_reg    <= count_next;
            ovalid_reg   <= ovalid_next;
            step_reg     <= step_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        sel_reg    <= sel_next;
        id_reg     <= id_next;
        tval_reg   <= tval_next;
        best_reg   <= best_next;
        bslot_reg  <= bslot_next;
        amount_reg <= amount_next;
        hvalid_reg <= hvalid_next;
        hid_reg    <= hid_next;
        odata_reg  <= odata_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

endmodule

`default_nettype wire
